/* design/imu_pkg.sv */
package imu_pkg;

	// Field widths of one sample set and one result word.
	localparam int AXIS_W = 16;
	localparam int TEMP_W = 8;
	localparam int CHAN_N = 6;

	// Offset of the temperature conversion.
	localparam logic [TEMP_W-1:0] TEMP_OFFSET = 8'd50;

	// Robot-frame channel order inside one history entry.
	localparam int CH_GX = 0;
	localparam int CH_GY = 1;
	localparam int CH_GZ = 2;
	localparam int CH_AX = 3;
	localparam int CH_AY = 4;
	localparam int CH_AZ = 5;

	// One remapped sample set as stored in the history memory.
	typedef logic [CHAN_N-1:0][AXIS_W-1:0] imu_set_t;

endpackage

/* design/imu_sample_if.sv */
interface imu_sample_if import imu_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic signed [AXIS_W-1:0] gyro_chip_x;
	logic signed [AXIS_W-1:0] gyro_chip_y;
	logic signed [AXIS_W-1:0] gyro_chip_z;
	logic signed [AXIS_W-1:0] accel_chip_x;
	logic signed [AXIS_W-1:0] accel_chip_y;
	logic signed [AXIS_W-1:0] accel_chip_z;
	logic        [TEMP_W-1:0] temp_raw;
	logic                     clear_history;

	modport source (
		output valid, gyro_chip_x, gyro_chip_y, gyro_chip_z,
		output accel_chip_x, accel_chip_y, accel_chip_z, temp_raw, clear_history,
		input  ready
	);

	modport sink (
		input  valid, gyro_chip_x, gyro_chip_y, gyro_chip_z,
		input  accel_chip_x, accel_chip_y, accel_chip_z, temp_raw, clear_history,
		output ready
	);

endinterface

/* design/imu_avg_if.sv */
interface imu_avg_if import imu_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic signed [AXIS_W-1:0] avg_gyro_x;
	logic signed [AXIS_W-1:0] avg_gyro_y;
	logic signed [AXIS_W-1:0] avg_gyro_z;
	logic signed [AXIS_W-1:0] avg_accel_x;
	logic signed [AXIS_W-1:0] avg_accel_y;
	logic signed [AXIS_W-1:0] avg_accel_z;
	logic signed [TEMP_W-1:0] temperature;

	modport source (
		output valid, avg_gyro_x, avg_gyro_y, avg_gyro_z,
		output avg_accel_x, avg_accel_y, avg_accel_z, temperature,
		input  ready
	);

	modport sink (
		input  valid, avg_gyro_x, avg_gyro_y, avg_gyro_z,
		input  avg_accel_x, avg_accel_y, avg_accel_z, temperature,
		output ready
	);

endinterface

/* design/imu_ram.sv */
module imu_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 5
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/imu_axis_remap_moving_average.sv */
// IMU sample averager with chip-to-robot axis remapping.
//
// The sample channel takes one word per sample set: six chip-frame axes, a
// raw temperature byte and a clear request. The average channel returns one
// word per set: the six robot-frame window averages and the temperature.
// Each set is written into a history memory of WINDOW_DEPTH entries; the
// block then reads back every valid entry, one per cycle, accumulates six
// sums and divides them by the entry count with a bit-serial restoring
// divider that handles all six channels side by side.
// A set passes from acceptance through the read loop, a sign split and the
// bit-serial division to the output register; one set is worked at a time.
// The result sits in an output register, so a new set is accepted while the
// previous result still waits; a stalled receiver holds the result and blocks
// the next load of that register, so the block then waits with its next
// result and accepts no further set until the receiver takes the first.
// Reset empties the window (write slot and fill flag go to zero) and drops
// any pending result; the memory itself is not cleared, since only entries
// written after reset or a clear request are ever read.
module imu_axis_remap_moving_average import imu_pkg::*; #(
	parameter int WINDOW_DEPTH = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	imu_sample_if.sink       sample,
	imu_avg_if.source        average
);

	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW     = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = AXIS_W + CW;
	localparam int MAG_W  = SUM_W - 1;
	localparam int DC_W   = $clog2(MAG_W);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_LAST  = 6'b000100,
		ST_SETUP = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [SLOT_W-1:0] slot_q;
	logic              full_q;
	logic [CW-1:0]     cnt_q;
	logic [SLOT_W-1:0] rd_idx_q;
	logic              rd_vld_s1;
	logic [DC_W-1:0]   div_cnt_q;
	logic [TEMP_W-1:0] temp_q;

	logic signed [SUM_W-1:0] sum_q  [CHAN_N];
	logic        [MAG_W-1:0] quo_q  [CHAN_N];
	logic        [CW-1:0]    rem_q  [CHAN_N];
	logic                    neg_q  [CHAN_N];

	logic              out_valid_q;
	logic [AXIS_W-1:0] out_avg_q [CHAN_N];
	logic [TEMP_W-1:0] out_temp_q;

	logic              accept;
	logic [SLOT_W-1:0] slot_eff;
	logic              full_eff;
	logic [CW-1:0]     next_c;
	logic              wrap;
	imu_set_t          wr_set;
	logic [CHAN_N*AXIS_W-1:0] rd_data;
	logic              last_issue;
	logic              out_load;

	assign accept = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);

	// Axis remap into the robot frame; negation wraps in 16 bits.
	always_comb begin
		wr_set[CH_GX] = AXIS_W'(-sample.gyro_chip_x);
		wr_set[CH_GY] = AXIS_W'(-sample.gyro_chip_y);
		wr_set[CH_GZ] = sample.gyro_chip_z;
		wr_set[CH_AX] = AXIS_W'(-sample.accel_chip_y);
		wr_set[CH_AY] = sample.accel_chip_x;
		wr_set[CH_AZ] = sample.accel_chip_z;
	end

	// Write slot and fill flag after this set; a clear request restarts the window.
	always_comb begin
		slot_eff = sample.clear_history ? '0 : slot_q;
		full_eff = sample.clear_history ? 1'b0 : full_q;
		next_c   = CW'(slot_eff) + CW'(1);
		wrap     = (next_c == CW'(WINDOW_DEPTH));
	end

	assign last_issue = ((CW'(rd_idx_q) + CW'(1)) == cnt_q);
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || average.ready);

	imu_ram #(
		.WIDTH (CHAN_N * AXIS_W),
		.DEPTH (WINDOW_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (slot_eff),
		.wdata (wr_set),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	// Sequencer, window bookkeeping and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			full_q      <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (average.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						slot_q  <= wrap ? '0 : next_c[SLOT_W-1:0];
						full_q  <= full_eff || wrap;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (last_issue) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST:  state_q <= ST_SETUP;
				ST_SETUP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: read index, accumulation, sign split, restoring division and the output registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q    <= (full_eff || wrap) ? CW'(WINDOW_DEPTH) : next_c;
			rd_idx_q <= '0;
			temp_q   <= TEMP_OFFSET - sample.temp_raw;
		end else if (state_q == ST_READ) begin
			rd_idx_q <= rd_idx_q + SLOT_W'(1);
		end
		if (state_q == ST_SETUP) begin
			div_cnt_q <= DC_W'(MAG_W - 1);
		end else if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q - DC_W'(1);
		end
		for (int c = 0; c < CHAN_N; c++) begin
			if (accept) begin
				sum_q[c] <= '0;
			end else if (rd_vld_s1) begin
				sum_q[c] <= sum_q[c] + SUM_W'($signed(rd_data[c*AXIS_W +: AXIS_W]));
			end
			if (state_q == ST_SETUP) begin
				neg_q[c] <= sum_q[c][SUM_W-1];
				quo_q[c] <= sum_q[c][SUM_W-1] ? MAG_W'(-sum_q[c]) : MAG_W'(sum_q[c]);
				rem_q[c] <= '0;
			end else if (state_q == ST_DIV) begin
				if ({rem_q[c], quo_q[c][MAG_W-1]} >= {1'b0, cnt_q}) begin
					rem_q[c] <= CW'({rem_q[c], quo_q[c][MAG_W-1]} - {1'b0, cnt_q});
					quo_q[c] <= {quo_q[c][MAG_W-2:0], 1'b1};
				end else begin
					rem_q[c] <= CW'({rem_q[c], quo_q[c][MAG_W-1]});
					quo_q[c] <= {quo_q[c][MAG_W-2:0], 1'b0};
				end
			end
			if (out_load) begin
				out_avg_q[c] <= neg_q[c] ? AXIS_W'(-quo_q[c][AXIS_W-1:0])
				                         : quo_q[c][AXIS_W-1:0];
			end
		end
		if (out_load) begin
			out_temp_q <= temp_q;
		end
	end

	// Result word.
	assign average.valid       = out_valid_q;
	assign average.avg_gyro_x  = out_avg_q[CH_GX];
	assign average.avg_gyro_y  = out_avg_q[CH_GY];
	assign average.avg_gyro_z  = out_avg_q[CH_GZ];
	assign average.avg_accel_x = out_avg_q[CH_AX];
	assign average.avg_accel_y = out_avg_q[CH_AY];
	assign average.avg_accel_z = out_avg_q[CH_AZ];
	assign average.temperature = out_temp_q;

endmodule
